@@ hdl/jbcc_pkg.sv @@
// Package for the journal block content classifier.
// Holds the summary record passed from the front end to the back end, plus the
// verdict codes and inode mode constants. Depends on nothing.
package jbcc_pkg;

  // Verdict codes for a block
  localparam logic [1:0] CLASS_INODE = 2'd0;
  localparam logic [1:0] CLASS_DIR   = 2'd1;
  localparam logic [1:0] CLASS_META  = 2'd2;
  localparam logic [1:0] CLASS_DATA  = 2'd3;

  // Inode type codes reported for the first valid slot
  localparam logic [2:0] TYPE_REG     = 3'd0;
  localparam logic [2:0] TYPE_DIR     = 3'd1;
  localparam logic [2:0] TYPE_SYMLINK = 3'd2;
  localparam logic [2:0] TYPE_CHARDEV = 3'd3;
  localparam logic [2:0] TYPE_BLKDEV  = 3'd4;
  localparam logic [2:0] TYPE_FIFO    = 3'd5;
  localparam logic [2:0] TYPE_SOCKET  = 3'd6;
  localparam logic [2:0] TYPE_UNKNOWN = 3'd7;

  // File format field of the inode mode
  localparam logic [15:0] MODE_FMT_MASK = 16'hF000;
  localparam logic [15:0] MODE_REG      = 16'h8000;
  localparam logic [15:0] MODE_DIR      = 16'h4000;
  localparam logic [15:0] MODE_SYMLINK  = 16'hA000;
  localparam logic [15:0] MODE_CHARDEV  = 16'h2000;
  localparam logic [15:0] MODE_BLKDEV   = 16'h6000;
  localparam logic [15:0] MODE_FIFO     = 16'h1000;
  localparam logic [15:0] MODE_SOCKET   = 16'hC000;

  // Upper bound (exclusive) for a block-number-like word
  localparam logic [31:0] WORD_LIMIT = 32'h00FF_FFFF;

  // Word offsets inside one inode slot
  localparam int OFF_MODE    = 0;
  localparam int OFF_SIZE_LO = 1;
  localparam int OFF_LINKS   = 6;
  localparam int OFF_SIZE_HI = 27;

  // Per-block summary handed from the front end to the back end
  typedef struct packed {
    logic [5:0]  inode_count;
    logic [5:0]  first_index;
    logic        first_found;
    logic [15:0] first_mode;
    logic [63:0] first_size;
    logic [15:0] first_links;
    logic        dir_match;
    logic        meta_hit;
  } jbcc_summary_t;

endpackage

@@ hdl/jbcc_front.sv @@
// Front end of the journal block content classifier.
// Walks the words of one block, keeps the per-block tallies and emits a
// summary record at the last word. Uses jbcc_pkg.
module jbcc_front #(
  parameter int BLOCK_WORDS = 1024,
  parameter int SLOT_WORDS  = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  logic [31:0]            word,
  input  logic                   last,
  output logic                   push,
  output jbcc_pkg::jbcc_summary_t summary
);

  localparam int NUM_SLOTS = BLOCK_WORDS / SLOT_WORDS;
  localparam int IW        = $clog2(BLOCK_WORDS + 1);
  localparam int PW        = $clog2(BLOCK_WORDS);
  localparam int OW        = $clog2(SLOT_WORDS);
  localparam int SW        = $clog2(NUM_SLOTS + 2);
  localparam int XW        = (SW > 6) ? SW : 6;
  localparam int META_MIN  = BLOCK_WORDS / 4;

  logic [IW-1:0] word_idx_r, word_idx_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [5:0]    inode_tally_r, inode_tally_nxt;
  logic [PW-1:0] pattern_r, pattern_nxt;
  logic [31:0]   dir_head_r, dir_head_nxt;
  logic          dir_match_r, dir_match_nxt;
  logic [15:0]   slot_mode_r, slot_mode_nxt;
  logic [31:0]   slot_size_lo_r, slot_size_lo_nxt;
  logic          first_found_r, first_found_nxt;
  logic [15:0]   first_mode_r, first_mode_nxt;
  logic [63:0]   first_size_r, first_size_nxt;
  logic [15:0]   first_links_r, first_links_nxt;
  logic [SW-1:0] first_slot_r, first_slot_nxt;

  logic          active;
  logic          full_slot;
  logic [15:0]   links;
  logic [16:0]   rec_len;
  logic [XW-1:0] first_slot_x;

  assign active    = (word_idx_r < IW'(BLOCK_WORDS));
  assign full_slot = (slot_r < SW'(NUM_SLOTS));
  assign links     = word[31:16];
  assign rec_len   = {1'b0, word[15:0]};

  // Per-word update of the block tallies
  always_comb begin
    word_idx_nxt     = word_idx_r;
    off_nxt          = off_r;
    slot_nxt         = slot_r;
    inode_tally_nxt  = inode_tally_r;
    pattern_nxt      = pattern_r;
    dir_head_nxt     = dir_head_r;
    dir_match_nxt    = dir_match_r;
    slot_mode_nxt    = slot_mode_r;
    slot_size_lo_nxt = slot_size_lo_r;
    first_found_nxt  = first_found_r;
    first_mode_nxt   = first_mode_r;
    first_size_nxt   = first_size_r;
    first_links_nxt  = first_links_r;
    first_slot_nxt   = first_slot_r;
    if (take && active) begin
      // Directory-entry header lives in words 0 and 1
      if (word_idx_r == IW'(0)) begin
        dir_head_nxt = word;
      end
      if (word_idx_r == IW'(1)) begin
        dir_match_nxt = (dir_head_r != 32'd0) && (dir_head_r < jbcc_pkg::WORD_LIMIT) &&
                        (rec_len >= 17'd8) && (rec_len <= 17'(BLOCK_WORDS * 4)) &&
                        (word[23:16] != 8'd0);
      end
      // Block-number-like words, the final word excluded
      if (!last && (word_idx_r < IW'(BLOCK_WORDS - 1)) && (word != 32'd0) &&
          (word < jbcc_pkg::WORD_LIMIT)) begin
        pattern_nxt = pattern_r + PW'(1);
      end
      // Inode slot fields
      if (full_slot) begin
        if (off_r == OW'(jbcc_pkg::OFF_MODE)) begin
          slot_mode_nxt = word[15:0];
        end else if (off_r == OW'(jbcc_pkg::OFF_SIZE_LO)) begin
          slot_size_lo_nxt = word;
        end else if (off_r == OW'(jbcc_pkg::OFF_LINKS)) begin
          if ((slot_mode_r != 16'd0) && (links != 16'd0)) begin
            if (inode_tally_r != 6'd63) begin
              inode_tally_nxt = inode_tally_r + 6'd1;
            end
            if (!first_found_r) begin
              first_found_nxt = 1'b1;
              first_mode_nxt  = slot_mode_r;
              first_size_nxt  = {32'd0, slot_size_lo_r};
              first_links_nxt = links;
              first_slot_nxt  = slot_r + SW'(1);
            end
          end
        end else if (off_r == OW'(jbcc_pkg::OFF_SIZE_HI)) begin
          if (first_found_r && (first_slot_r == slot_r + SW'(1))) begin
            first_size_nxt = {word, first_size_r[31:0]};
          end
        end
      end
      // Position within the block
      word_idx_nxt = word_idx_r + IW'(1);
      if (off_r == OW'(SLOT_WORDS - 1)) begin
        off_nxt  = '0;
        slot_nxt = slot_r + SW'(1);
      end else begin
        off_nxt = off_r + OW'(1);
      end
    end
  end

  // Summary of the block as it stands after the last word
  assign first_slot_x = XW'(first_slot_nxt);
  always_comb begin
    push                = take && last;
    summary.inode_count = inode_tally_nxt;
    summary.first_index = (first_slot_x > XW'(63)) ? 6'd63 : first_slot_x[5:0];
    summary.first_found = first_found_nxt;
    summary.first_mode  = first_mode_nxt;
    summary.first_size  = first_size_nxt;
    summary.first_links = first_links_nxt;
    summary.dir_match   = dir_match_nxt;
    summary.meta_hit    = (pattern_nxt > PW'(META_MIN));
  end

  // Tallies are cleared at reset and as each block's last word is taken
  always_ff @(posedge clk) begin
    if (!rst_n || (take && last)) begin
      word_idx_r     <= '0;
      off_r          <= '0;
      slot_r         <= '0;
      inode_tally_r  <= '0;
      pattern_r      <= '0;
      dir_head_r     <= '0;
      dir_match_r    <= 1'b0;
      slot_mode_r    <= '0;
      slot_size_lo_r <= '0;
      first_found_r  <= 1'b0;
      first_mode_r   <= '0;
      first_size_r   <= '0;
      first_links_r  <= '0;
      first_slot_r   <= '0;
    end else begin
      word_idx_r     <= word_idx_nxt;
      off_r          <= off_nxt;
      slot_r         <= slot_nxt;
      inode_tally_r  <= inode_tally_nxt;
      pattern_r      <= pattern_nxt;
      dir_head_r     <= dir_head_nxt;
      dir_match_r    <= dir_match_nxt;
      slot_mode_r    <= slot_mode_nxt;
      slot_size_lo_r <= slot_size_lo_nxt;
      first_found_r  <= first_found_nxt;
      first_mode_r   <= first_mode_nxt;
      first_size_r   <= first_size_nxt;
      first_links_r  <= first_links_nxt;
      first_slot_r   <= first_slot_nxt;
    end
  end

endmodule

@@ hdl/jbcc_queue.sv @@
// Two-entry queue of block summaries between front and back end.
// Uses jbcc_pkg for the summary record.
module jbcc_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  jbcc_pkg::jbcc_summary_t wr_data,
  output logic                    ready,
  output logic                    valid,
  output jbcc_pkg::jbcc_summary_t rd_data,
  input  logic                    pop
);

  jbcc_pkg::jbcc_summary_t entry_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       do_push;
  logic       do_pop;

  assign ready   = (count_r != 2'd2);
  assign valid   = (count_r != 2'd0);
  assign rd_data = entry_r[rd_ptr_r];
  assign do_push = push && ready;
  assign do_pop  = pop && valid;

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/jbcc_back.sv @@
// Back end of the journal block content classifier.
// Turns a block summary into the verdict and holds it in the output register.
// Uses jbcc_pkg.
module jbcc_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  jbcc_pkg::jbcc_summary_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              block_class,
  output logic [5:0]              inode_count,
  output logic [5:0]              first_index,
  output logic [2:0]              first_type,
  output logic [63:0]             first_size,
  output logic [15:0]             first_links
);

  logic        out_valid_r;
  logic [1:0]  class_r, class_nxt;
  logic [5:0]  count_r;
  logic [5:0]  index_r;
  logic [2:0]  type_r, type_nxt;
  logic [63:0] size_r;
  logic [15:0] links_r;
  logic [15:0] fmt;

  assign q_pop = q_valid && (!out_valid_r || out_ready);
  assign fmt   = q_data.first_mode & jbcc_pkg::MODE_FMT_MASK;

  // Verdict priority: inode table, directory, metadata, file data
  always_comb begin
    if (q_data.inode_count >= 6'd2) begin
      class_nxt = jbcc_pkg::CLASS_INODE;
    end else if (q_data.dir_match) begin
      class_nxt = jbcc_pkg::CLASS_DIR;
    end else if (q_data.meta_hit) begin
      class_nxt = jbcc_pkg::CLASS_META;
    end else begin
      class_nxt = jbcc_pkg::CLASS_DATA;
    end
  end

  // Inode type from the file format bits; regular when no inode was found
  always_comb begin
    case (fmt)
      jbcc_pkg::MODE_REG:     type_nxt = jbcc_pkg::TYPE_REG;
      jbcc_pkg::MODE_DIR:     type_nxt = jbcc_pkg::TYPE_DIR;
      jbcc_pkg::MODE_SYMLINK: type_nxt = jbcc_pkg::TYPE_SYMLINK;
      jbcc_pkg::MODE_CHARDEV: type_nxt = jbcc_pkg::TYPE_CHARDEV;
      jbcc_pkg::MODE_BLKDEV:  type_nxt = jbcc_pkg::TYPE_BLKDEV;
      jbcc_pkg::MODE_FIFO:    type_nxt = jbcc_pkg::TYPE_FIFO;
      jbcc_pkg::MODE_SOCKET:  type_nxt = jbcc_pkg::TYPE_SOCKET;
      default:                type_nxt = jbcc_pkg::TYPE_UNKNOWN;
    endcase
    if (!q_data.first_found) begin
      type_nxt = jbcc_pkg::TYPE_REG;
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      class_r <= class_nxt;
      count_r <= q_data.inode_count;
      type_r  <= type_nxt;
      if (q_data.first_found) begin
        index_r <= q_data.first_index;
        size_r  <= q_data.first_size;
        links_r <= q_data.first_links;
      end else begin
        index_r <= 6'd0;
        size_r  <= 64'd0;
        links_r <= 16'd0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign block_class = class_r;
  assign inode_count = count_r;
  assign first_index = index_r;
  assign first_type  = type_r;
  assign first_size  = size_r;
  assign first_links = links_r;

endmodule

@@ hdl/journal_block_content_classifier.sv @@
// Journal block content classifier: one word per cycle in, one verdict per block out.
// A block's summary enters the queue as its last word is taken and moves on into the
// output register once that is free; a held-off output stalls it in the queue.
// Throughput: one word every cycle; the per-word tally update in the front end sets it.
// in_tready drops only while two summaries wait in the queue behind a held-off output.
// Reset (rst_n low, synchronous) clears the tallies, the summary queue and the
// output valid flag; no clearing pass is needed.
// Uses jbcc_pkg, jbcc_front, jbcc_queue and jbcc_back.
module journal_block_content_classifier #(
  parameter int BLOCK_WORDS = 1024,
  parameter int SLOT_WORDS  = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // word[31:0]
  input  logic         in_tlast,   // last_word
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata   // block_class[1:0], valid_inode_count[7:2],
                                   // first_inode_index[13:8], first_type_code[16:14],
                                   // first_file_size[80:17], first_link_count[96:81],
                                   // zero[103:97]
);

  jbcc_pkg::jbcc_summary_t push_data;
  jbcc_pkg::jbcc_summary_t q_data;
  logic        take;
  logic        push;
  logic        q_ready;
  logic        q_valid;
  logic        q_pop;
  logic [1:0]  block_class;
  logic [5:0]  inode_count;
  logic [5:0]  first_index;
  logic [2:0]  first_type;
  logic [63:0] first_size;
  logic [15:0] first_links;

  // An input transfer needs room for a summary in the queue
  assign in_tready = q_ready;
  assign take      = in_tvalid && q_ready;

  jbcc_front #(
    .BLOCK_WORDS (BLOCK_WORDS),
    .SLOT_WORDS  (SLOT_WORDS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .word    (in_tdata),
    .last    (in_tlast),
    .push    (push),
    .summary (push_data)
  );

  jbcc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data (push_data),
    .ready   (q_ready),
    .valid   (q_valid),
    .rd_data (q_data),
    .pop     (q_pop)
  );

  jbcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .block_class (block_class),
    .inode_count (inode_count),
    .first_index (first_index),
    .first_type  (first_type),
    .first_size  (first_size),
    .first_links (first_links)
  );

  // Pack the verdict fields, lowest field first
  assign out_tdata = {7'd0, first_links, first_size, first_type, first_index,
                      inode_count, block_class};

`ifndef SYNTHESIS
  // The queue can never report full and empty at once
  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready || q_valid)
    else $error("summary queue both full and empty");

  // A transfer of the last word leaves a summary waiting in the queue
  a_last_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> q_valid)
    else $error("last word did not produce a summary");

  // A waiting summary moves into an empty output register
  a_back_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !out_tvalid) |=> out_tvalid)
    else $error("back end failed to load a waiting summary");
`endif

endmodule
